>>> hdl/sed_pkg.sv
package sed_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned ValueW = 12;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CntW   = 2;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [CntW-1:0] LastDigit = CntW'(3);

  localparam logic [CharW-1:0] ChQuote = 8'd34;
  localparam logic [CharW-1:0] ChNul   = 8'd0;
  localparam logic [CharW-1:0] ChLf    = 8'd10;
  localparam logic [CharW-1:0] ChBslash = 8'd92;
  localparam logic [CharW-1:0] ChLowR  = 8'd114;
  localparam logic [CharW-1:0] ChLowN  = 8'd110;
  localparam logic [CharW-1:0] ChLowT  = 8'd116;
  localparam logic [CharW-1:0] ChLowX  = 8'd120;
  localparam logic [CharW-1:0] ChUpX   = 8'd88;

  localparam logic [ValueW-1:0] ValCr  = 12'd13;
  localparam logic [ValueW-1:0] ValLf  = 12'd10;
  localparam logic [ValueW-1:0] ValTab = 12'd9;

  typedef enum logic [StatW-1:0] {
    STAT_OK      = 2'd0,
    STAT_NUL     = 2'd1,
    STAT_NEWLINE = 2'd2,
    STAT_UNKNOWN = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    MODE_NORMAL = 5'b00001,
    MODE_ESC    = 5'b00010,
    MODE_OCT    = 5'b00100,
    MODE_HEX0   = 5'b01000,
    MODE_HEX    = 5'b10000
  } mode_e;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              is_end;
    status_e           status;
  } result_t;

  // one queue entry: everything one input word produces
  typedef struct packed {
    result_t first;
    result_t second;
    logic    two;
  } entry_t;

endpackage

>>> hdl/sed_front.sv
module sed_front import sed_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [CharW-1:0] char_in_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output entry_t           q_entry_o
);

  mode_e             mode_q, mode_d;
  logic [ValueW-1:0] val_q, val_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  logic              accept;
  logic              emit0;
  result_t           p_res;
  logic              p_emit;
  mode_e             p_mode;
  logic              is_oct;
  logic              is_hex;
  logic [3:0]        hex_d;
  logic [CntW-1:0]   cnt_inc;
  logic [ValueW-1:0] oct_val;
  logic [ValueW-1:0] hex_val;
  entry_t            ent;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  assign is_oct  = (char_in_i >= 8'd48) && (char_in_i <= 8'd55);
  assign cnt_inc = cnt_q + CntW'(1);
  assign oct_val = {val_q[ValueW-4:0], char_in_i[2:0]};
  assign hex_val = {val_q[ValueW-5:0], hex_d};

  always_comb begin
    is_hex = 1'b1;
    hex_d  = 4'd0;
    if (char_in_i >= 8'd48 && char_in_i <= 8'd57) begin
      hex_d = char_in_i[3:0];
    end else if ((char_in_i >= 8'd65 && char_in_i <= 8'd70) ||
                 (char_in_i >= 8'd97 && char_in_i <= 8'd102)) begin
      hex_d = 4'(char_in_i[2:0] + 3'd1) + 4'd8;
    end else begin
      is_hex = 1'b0;
    end
  end

  // plain byte handling
  always_comb begin
    p_res  = '{value: {4'd0, char_in_i}, is_end: 1'b0, status: STAT_OK};
    p_emit = 1'b1;
    p_mode = MODE_NORMAL;
    if (char_in_i == ChQuote) begin
      p_res = '{value: '0, is_end: 1'b1, status: STAT_OK};
    end else if (char_in_i == ChNul) begin
      p_res = '{value: '0, is_end: 1'b1, status: STAT_NUL};
    end else if (char_in_i == ChLf) begin
      p_res.status = STAT_NEWLINE;
    end else if (char_in_i == ChBslash) begin
      p_emit = 1'b0;
      p_mode = MODE_ESC;
    end
  end

  always_comb begin
    mode_d = mode_q;
    val_d  = val_q;
    cnt_d  = cnt_q;
    ent    = '0;
    emit0  = 1'b0;
    unique case (mode_q)
      MODE_ESC: begin
        mode_d = MODE_NORMAL;
        val_d  = '0;
        cnt_d  = '0;
        if (is_oct) begin
          mode_d = MODE_OCT;
          val_d  = {9'd0, char_in_i[2:0]};
          cnt_d  = CntW'(1);
        end else if (char_in_i == ChLowX || char_in_i == ChUpX) begin
          mode_d = MODE_HEX0;
        end else begin
          emit0 = 1'b1;
          ent.first = '{value: {4'd0, char_in_i}, is_end: 1'b0, status: STAT_OK};
          if (char_in_i == ChLowR) begin
            ent.first.value = ValCr;
          end else if (char_in_i == ChLowN) begin
            ent.first.value = ValLf;
          end else if (char_in_i == ChLowT) begin
            ent.first.value = ValTab;
          end else if (char_in_i != ChBslash && char_in_i != ChQuote) begin
            ent.first.status = STAT_UNKNOWN;
          end
        end
      end
      MODE_OCT, MODE_HEX0, MODE_HEX: begin
        if ((mode_q == MODE_OCT && is_oct) || (mode_q != MODE_OCT && is_hex)) begin
          val_d  = (mode_q == MODE_OCT) ? oct_val : hex_val;
          cnt_d  = cnt_inc;
          mode_d = (mode_q == MODE_OCT) ? MODE_OCT : MODE_HEX;
          if (cnt_inc == LastDigit) begin
            emit0     = 1'b1;
            ent.first = '{value: val_d, is_end: 1'b0, status: STAT_OK};
            mode_d    = MODE_NORMAL;
            val_d     = '0;
            cnt_d     = '0;
          end
        end else begin
          // short escape: flush, then the byte as plain
          emit0      = 1'b1;
          ent.first  = '{value: val_q, is_end: 1'b0, status: STAT_OK};
          ent.second = p_res;
          ent.two    = p_emit;
          mode_d     = p_mode;
          val_d      = '0;
          cnt_d      = '0;
        end
      end
      default: begin
        emit0     = p_emit;
        ent.first = p_res;
        mode_d    = p_mode;
      end
    endcase
  end

  assign q_push_o  = accept && emit0;
  assign q_entry_o = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      val_q  <= '0;
      cnt_q  <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      val_q  <= val_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

>>> hdl/sed_queue.sv
module sed_queue import sed_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   head_valid_o,
  output entry_t head_o
);

  entry_t           mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign full_o       = (cnt_q == QCntW'(QDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

>>> hdl/sed_back.sv
module sed_back import sed_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  entry_t            head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ValueW-1:0] char_value_o,
  output logic              is_end_o,
  output logic [StatW-1:0]  status_o,
  output logic              last_of_item_o
);

  logic    valid_q, valid_d;
  logic    sel_q, sel_d;
  result_t res_q;
  logic    last_q;
  logic    load;
  logic    cur_last;
  result_t cur;

  assign load     = head_valid_i && (!valid_q || !out_stall_i);
  assign cur      = sel_q ? head_i.second : head_i.first;
  assign cur_last = sel_q || !head_i.two;
  assign pop_o    = load && cur_last;

  always_comb begin
    valid_d = valid_q;
    sel_d   = sel_q;
    if (load) begin
      valid_d = 1'b1;
      sel_d   = !cur_last;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sel_q   <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q  <= cur;
      last_q <= cur_last;
    end
  end

  assign out_valid_o    = valid_q;
  assign char_value_o   = res_q.value;
  assign is_end_o       = res_q.is_end;
  assign status_o       = res_q.status;
  assign last_of_item_o = last_q;

endmodule

>>> hdl/string_escape_decoder.sv
// Decodes the body of a quoted string literal, one raw byte per input word, and
// gives one or two result words per byte (none for a backslash, the x or X that
// opens a hex escape, or a digit that does not yet finish a numeric escape). The
// front stage takes a byte in every cycle while its two-entry result queue has
// room; its only loop is the mode/value register update. The back stage sends
// one result word per cycle from an output register while the output is not
// stalled, so a byte that yields two words (a short numeric escape flushed by the
// byte that follows) goes out as two words from one queue entry. An accepted
// byte's first result is registered in the queue, then in the output register.
module string_escape_decoder import sed_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CharW-1:0]  char_in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ValueW-1:0] char_value_o,
  output logic              is_end_o,
  output logic [StatW-1:0]  status_o,
  output logic              last_of_item_o
);

  logic   q_push;
  logic   q_full;
  logic   q_pop;
  logic   q_head_valid;
  entry_t q_entry;
  entry_t q_head;

  sed_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .char_in_i  (char_in_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (q_entry)
  );

  sed_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .entry_i      (q_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_valid_o (q_head_valid),
    .head_o       (q_head)
  );

  sed_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (q_head_valid),
    .head_i         (q_head),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .char_value_o   (char_value_o),
    .is_end_o       (is_end_o),
    .status_o       (status_o),
    .last_of_item_o (last_of_item_o)
  );

endmodule
